### sv/gdw_pkg.sv
// Shared types, codes and defaults of the depth-first grid maze walker.
package gdw_pkg;

  localparam int COORD_W    = 6;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Largest grid side the 6-bit coordinates can address.
  localparam int COORD_SPAN = 64;

  // Operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_BEGIN = 2'd3;

  // Cell marks.
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_WALL = 2'd1;
  localparam logic [1:0] MARK_PATH = 2'd2;
  localparam logic [1:0] MARK_DEAD = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_FORWARD = 3'd0;
  localparam logic [2:0] ST_BACK    = 3'd1;
  localparam logic [2:0] ST_GOAL    = 3'd2;
  localparam logic [2:0] ST_NOPATH  = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;
  localparam logic [2:0] ST_ACK     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW    = 3'd5;

  // Configuration reset values.
  localparam logic [6:0]         RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]         RST_GRID_HEIGHT = 7'd64;
  localparam logic [COORD_W-1:0] RST_START_COL   = 6'd0;
  localparam logic [COORD_W-1:0] RST_START_ROW   = 6'd0;
  localparam logic [COORD_W-1:0] RST_GOAL_COL    = 6'd63;
  localparam logic [COORD_W-1:0] RST_GOAL_ROW    = 6'd63;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               is_wall;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] walker_col;
    logic [COORD_W-1:0] walker_row;
    logic [2:0]         status;
    logic [1:0]         cell_mark;
  } rsp_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pos_t;

endpackage

### sv/gdw_cell_store.sv
// Cell mark memory with address mapping, store bounds and a clearing pass after reset.
module gdw_cell_store #(
  parameter int STORE_COLS = gdw_pkg::DEF_MAX_COLS,
  parameter int STORE_ROWS = gdw_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [gdw_pkg::COORD_W-1:0] wr_col,
  input  logic [gdw_pkg::COORD_W-1:0] wr_row,
  input  logic [1:0]                  wr_mark,
  input  logic [gdw_pkg::COORD_W-1:0] rd_col,
  input  logic [gdw_pkg::COORD_W-1:0] rd_row,
  output logic [1:0]                  rd_mark,
  output logic                        ready
);

  localparam int DEPTH = STORE_COLS * STORE_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_q;
  logic          rd_in;
  logic [AW-1:0] clr_addr;
  logic          wr_in;
  logic          rd_hit;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // A cell lies in the store when both coordinates are below the store sides.
  assign wr_in  = ({1'b0, wr_col} < 7'(STORE_COLS)) && ({1'b0, wr_row} < 7'(STORE_ROWS));
  assign rd_hit = ({1'b0, rd_col} < 7'(STORE_COLS)) && ({1'b0, rd_row} < 7'(STORE_ROWS));

  assign wr_addr = wr_in  ? AW'(AW'(wr_row) * AW'(STORE_COLS) + AW'(wr_col)) : '0;
  assign rd_addr = rd_hit ? AW'(AW'(rd_row) * AW'(STORE_COLS) + AW'(rd_col)) : '0;

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_addr] <= gdw_pkg::MARK_FREE;
    end else if (wr_en && wr_in) begin
      mem[wr_addr] <= wr_mark;
    end
    rd_q  <= mem[rd_addr];
    rd_in <= rd_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready    <= 1'b0;
      clr_addr <= '0;
    end else if (!ready) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        ready <= 1'b1;
      end
    end
  end

  // Cells outside the store read as wall.
  assign rd_mark = rd_in ? rd_q : gdw_pkg::MARK_WALL;

endmodule

### sv/gdw_path_stack.sv
// Path stack memory: one write port and one registered read port.
module gdw_path_stack #(
  parameter int DEPTH = gdw_pkg::DEF_MAX_COLS * gdw_pkg::DEF_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gdw_pkg::pos_t            wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output gdw_pkg::pos_t            rd_data
);

  gdw_pkg::pos_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/grid_maze_depth_first_walker.sv
// Top level of the depth-first grid maze walker: sequencer, registers and memories.
//
// The walker keeps a two-bit mark for every cell of a MAX_COLS by MAX_ROWS grid
// (capped at 64 by 64, the reach of the 6-bit coordinates) in a synchronous
// cell memory, and the path of positions it has moved through in a stack
// memory. Each command item writes a cell as free or wall, reads a cell mark,
// begins a walk (walker to the start cell, stack emptied, marks kept) or takes
// one depth-first step, and every item gives exactly one response item. After
// reset the cell memory is cleared one entry per cycle, covering all its
// min(MAX_COLS,64) * min(MAX_ROWS,64) entries (4096 by default); no command is
// taken during that pass, while configuration writes are. A write, a begin
// and a step at the goal finish in the execute state, and a read finishes
// in a data state once the registered cell read has returned. Any other step
// probes the four neighbors, and the cell memory's single read port sets the
// pace: they are probed one per cycle in the order +col, +row, -col, -row,
// each read overlapping the test of the one before, and the step stops at
// the first free one. A dead end marks its cell dead and finishes at the
// last probe unless it returns to a stacked cell, for which a pop state adds
// one stack memory read. A new command is accepted in the cycle after the
// response is loaded, even if the response is still stalled, and a response
// that cannot leave waits in a hold register. The design is strictly one item
// at a time, so a cell is never read and written in the same cycle and no
// forwarding is needed. Configuration is to be written only while the block
// is idle.
module grid_maze_depth_first_walker #(
  parameter int MAX_COLS = gdw_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gdw_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  gdw_pkg::cmd_t                  cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output gdw_pkg::rsp_t                  rsp,
  input  logic                           cfg_we,
  input  logic [gdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_COLS  = (MAX_COLS < gdw_pkg::COORD_SPAN) ? MAX_COLS : gdw_pkg::COORD_SPAN;
  localparam int STORE_ROWS  = (MAX_ROWS < gdw_pkg::COORD_SPAN) ? MAX_ROWS : gdw_pkg::COORD_SPAN;
  localparam int STACK_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int SCW         = $clog2(STACK_DEPTH + 1);
  localparam int CW          = gdw_pkg::COORD_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  // Configuration registers.
  logic [6:0]    grid_width;
  logic [6:0]    grid_height;
  logic [CW-1:0] start_col;
  logic [CW-1:0] start_row;
  logic [CW-1:0] goal_col;
  logic [CW-1:0] goal_row;

  // Control state.
  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [CW-1:0]  walker_col;
  logic [CW-1:0]  walker_col_next;
  logic [CW-1:0]  walker_row;
  logic [CW-1:0]  walker_row_next;
  logic [SCW-1:0] stack_count;
  logic [SCW-1:0] stack_count_next;
  logic [1:0]     probe;
  logic [1:0]     probe_next;

  // Payload registers.
  gdw_pkg::cmd_t cur;
  gdw_pkg::rsp_t hold;
  gdw_pkg::rsp_t res;
  logic          done;
  logic          out_free;
  logic          accept;

  // Cell store and stack connections.
  logic          cs_we;
  logic [CW-1:0] cs_wcol;
  logic [CW-1:0] cs_wrow;
  logic [1:0]    cs_wmark;
  logic [CW-1:0] cs_rcol;
  logic [CW-1:0] cs_rrow;
  logic [1:0]    cs_rmark;
  logic          store_ready;
  logic          st_we;
  gdw_pkg::pos_t st_wdata;
  gdw_pkg::pos_t st_rdata;
  logic [SCW-1:0] count_m2;

  // Neighbor geometry.
  logic [6:0]    gw;
  logic [6:0]    gh;
  logic [6:0]    wc7;
  logic [6:0]    wr7;
  logic [CW-1:0] nb_col [4];
  logic [CW-1:0] nb_row [4];
  logic [3:0]    nb_ok;
  logic          at_goal;
  logic          found;
  logic [1:0]    probe_inc;

  gdw_cell_store #(
    .STORE_COLS (STORE_COLS),
    .STORE_ROWS (STORE_ROWS)
  ) u_cells (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cs_we),
    .wr_col  (cs_wcol),
    .wr_row  (cs_wrow),
    .wr_mark (cs_wmark),
    .rd_col  (cs_rcol),
    .rd_row  (cs_rrow),
    .rd_mark (cs_rmark),
    .ready   (store_ready)
  );

  gdw_path_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (stack_count[SAW-1:0]),
    .wr_data (st_wdata),
    .rd_addr (count_m2[SAW-1:0]),
    .rd_data (st_rdata)
  );

  // Usable grid: the configured size, capped at the store size.
  assign gw  = (grid_width  > 7'(STORE_COLS)) ? 7'(STORE_COLS) : grid_width;
  assign gh  = (grid_height > 7'(STORE_ROWS)) ? 7'(STORE_ROWS) : grid_height;
  assign wc7 = {1'b0, walker_col};
  assign wr7 = {1'b0, walker_row};

  // Neighbors in probe order: +col, +row, -col, -row. A neighbor qualifies
  // only if it lies inside the usable grid; its mark is tested separately.
  assign nb_col[0] = walker_col + CW'(1);
  assign nb_row[0] = walker_row;
  assign nb_col[1] = walker_col;
  assign nb_row[1] = walker_row + CW'(1);
  assign nb_col[2] = walker_col - CW'(1);
  assign nb_row[2] = walker_row;
  assign nb_col[3] = walker_col;
  assign nb_row[3] = walker_row - CW'(1);

  assign nb_ok[0] = ((wc7 + 7'd1) < gw) && (wr7 < gh);
  assign nb_ok[1] = (wc7 < gw) && ((wr7 + 7'd1) < gh);
  assign nb_ok[2] = (walker_col != '0) && ((wc7 - 7'd1) < gw) && (wr7 < gh);
  assign nb_ok[3] = (walker_row != '0) && (wc7 < gw) && ((wr7 - 7'd1) < gh);

  assign at_goal   = (walker_col == goal_col) && (walker_row == goal_row);
  assign found     = nb_ok[probe] && (cs_rmark == gdw_pkg::MARK_FREE);
  assign probe_inc = probe + 2'd1;
  assign count_m2  = stack_count - SCW'(2);

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = !((state == S_IDLE) && store_ready);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign st_wdata.col = nb_col[probe];
  assign st_wdata.row = nb_row[probe];

  always_comb begin
    state_next       = state;
    walker_col_next  = walker_col;
    walker_row_next  = walker_row;
    stack_count_next = stack_count;
    probe_next       = probe;
    done             = 1'b0;
    res              = '0;
    cs_we            = 1'b0;
    cs_wcol          = walker_col;
    cs_wrow          = walker_row;
    cs_wmark         = gdw_pkg::MARK_PATH;
    // By default the cell read looks one probe ahead, so each neighbor's
    // mark is ready in the cycle its test runs.
    cs_rcol          = nb_col[probe_inc];
    cs_rrow          = nb_row[probe_inc];
    st_we            = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur.operation)
          gdw_pkg::OP_WRITE: begin
            cs_we    = 1'b1;
            cs_wcol  = cur.cell_col;
            cs_wrow  = cur.cell_row;
            cs_wmark = cur.is_wall ? gdw_pkg::MARK_WALL : gdw_pkg::MARK_FREE;
            done     = 1'b1;
            res      = '{walker_col, walker_row, gdw_pkg::ST_ACK, gdw_pkg::MARK_FREE};
          end
          gdw_pkg::OP_STEP: begin
            // The current cell becomes path whether or not it is the goal.
            cs_we = 1'b1;
            if (at_goal) begin
              done = 1'b1;
              res  = '{walker_col, walker_row, gdw_pkg::ST_GOAL, gdw_pkg::MARK_FREE};
            end else begin
              cs_rcol    = nb_col[0];
              cs_rrow    = nb_row[0];
              probe_next = 2'd0;
              state_next = S_SCAN;
            end
          end
          gdw_pkg::OP_READ: begin
            cs_rcol    = cur.cell_col;
            cs_rrow    = cur.cell_row;
            state_next = S_RDATA;
          end
          default: begin
            walker_col_next  = start_col;
            walker_row_next  = start_row;
            stack_count_next = '0;
            done             = 1'b1;
            res              = '{start_col, start_row, gdw_pkg::ST_ACK, gdw_pkg::MARK_FREE};
          end
        endcase
      end
      S_SCAN: begin
        if (found) begin
          walker_col_next = nb_col[probe];
          walker_row_next = nb_row[probe];
          // A full stack drops the push but the move still happens.
          if (stack_count < SCW'(STACK_DEPTH)) begin
            st_we            = 1'b1;
            stack_count_next = stack_count + SCW'(1);
          end
          done = 1'b1;
          res  = '{nb_col[probe], nb_row[probe], gdw_pkg::ST_FORWARD, gdw_pkg::MARK_FREE};
        end else if (probe == 2'd3) begin
          cs_we    = 1'b1;
          cs_wmark = gdw_pkg::MARK_DEAD;
          if (stack_count == '0) begin
            done = 1'b1;
            res  = '{walker_col, walker_row, gdw_pkg::ST_NOPATH, gdw_pkg::MARK_FREE};
          end else if (stack_count == SCW'(1)) begin
            stack_count_next = '0;
            walker_col_next  = start_col;
            walker_row_next  = start_row;
            done             = 1'b1;
            res = '{start_col, start_row, gdw_pkg::ST_BACK, gdw_pkg::MARK_FREE};
          end else begin
            // The stack read of the new top was issued this cycle.
            stack_count_next = stack_count - SCW'(1);
            state_next       = S_POP;
          end
        end else begin
          probe_next = probe_inc;
        end
      end
      S_POP: begin
        walker_col_next = st_rdata.col;
        walker_row_next = st_rdata.row;
        done            = 1'b1;
        res = '{st_rdata.col, st_rdata.row, gdw_pkg::ST_BACK, gdw_pkg::MARK_FREE};
      end
      S_RDATA: begin
        done = 1'b1;
        res  = '{walker_col, walker_row, gdw_pkg::ST_READ, cs_rmark};
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A finished response goes out at once if the output register is free,
    // otherwise it waits in the hold register.
    if (done) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      walker_col  <= '0;
      walker_row  <= '0;
      stack_count <= '0;
      probe       <= '0;
      rsp_valid   <= 1'b0;
      grid_width  <= gdw_pkg::RST_GRID_WIDTH;
      grid_height <= gdw_pkg::RST_GRID_HEIGHT;
      start_col   <= gdw_pkg::RST_START_COL;
      start_row   <= gdw_pkg::RST_START_ROW;
      goal_col    <= gdw_pkg::RST_GOAL_COL;
      goal_row    <= gdw_pkg::RST_GOAL_ROW;
    end else begin
      state       <= state_next;
      walker_col  <= walker_col_next;
      walker_row  <= walker_row_next;
      stack_count <= stack_count_next;
      probe       <= probe_next;
      if ((done || (state == S_HOLD)) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          gdw_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          gdw_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
          gdw_pkg::CFG_START_COL:   start_col   <= cfg_data[CW-1:0];
          gdw_pkg::CFG_START_ROW:   start_row   <= cfg_data[CW-1:0];
          gdw_pkg::CFG_GOAL_COL:    goal_col    <= cfg_data[CW-1:0];
          gdw_pkg::CFG_GOAL_ROW:    goal_row    <= cfg_data[CW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= cmd;
    end
    if (done) begin
      if (out_free) begin
        rsp <= res;
      end else begin
        hold <= res;
      end
    end else if ((state == S_HOLD) && out_free) begin
      rsp <= hold;
    end
  end

  // The stack count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= SCW'(STACK_DEPTH))
    else $error("stack count beyond stack depth");

  // A return to a stacked cell leaves at least one entry on the stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (stack_count != '0))
    else $error("pop to a stacked cell with an empty stack");

  // Probing is entered only from a step's first cycle.
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_SCAN) |-> ($past(state) == S_EXEC))
    else $error("neighbor probing entered from a wrong state");

  // No item is worked on while the cell memory is still being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    !store_ready |-> ((state == S_IDLE) && !done))
    else $error("item in progress during the clearing pass");

endmodule

### tb/grid_maze_depth_first_walker_tb.sv
// Self-checking testbench for the depth-first grid maze walker.
`timescale 1ns / 1ps

module grid_maze_depth_first_walker_tb;

  // Usable grid sides are capped by the parameters and by the 6-bit coordinates.
  localparam int USE_COLS = (gdw_pkg::DEF_MAX_COLS < gdw_pkg::COORD_SPAN) ?
                            gdw_pkg::DEF_MAX_COLS : gdw_pkg::COORD_SPAN;
  localparam int USE_ROWS = (gdw_pkg::DEF_MAX_ROWS < gdw_pkg::COORD_SPAN) ?
                            gdw_pkg::DEF_MAX_ROWS : gdw_pkg::COORD_SPAN;
  localparam int TRAIL_DEPTH = gdw_pkg::DEF_MAX_COLS * gdw_pkg::DEF_MAX_ROWS;
  // The limit sits well above the clearing pass after reset.
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  gdw_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gdw_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [gdw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_maze_depth_first_walker u_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Items waiting to be driven, and the responses predicted for accepted items.
  gdw_pkg::cmd_t pending_cmds[$];
  gdw_pkg::rsp_t expected_rsps[$];

  // Percentage chance of starting a gap on either side; zero gives stretches
  // with no idling at all.
  int idle_pct = 25;
  int error_count = 0;
  int rsp_count = 0;
  int hold_left = 0;
  int recv_gap = 0;
  int send_gap = 0;
  int quiet_cycles = 0;

  // Shadow copy of the walker: cell marks, the trail of positions, the walker
  // itself and the configuration registers.
  logic [1:0] cell_store[gdw_pkg::COORD_SPAN][gdw_pkg::COORD_SPAN];
  gdw_pkg::pos_t trail[TRAIL_DEPTH];
  int trail_depth;
  logic [gdw_pkg::COORD_W-1:0] at_col, at_row;
  logic [6:0] grid_w, grid_h;
  logic [gdw_pkg::COORD_W-1:0] start_c, start_r, goal_c, goal_r;

  function automatic logic [1:0] cell_mark_at(int c, int r);
    if (c >= USE_COLS || r >= USE_ROWS) return gdw_pkg::MARK_WALL;
    return cell_store[r][c];
  endfunction

  function automatic void set_mark(int c, int r, logic [1:0] m);
    if (c < USE_COLS && r < USE_ROWS) cell_store[r][c] = m;
  endfunction

  // A neighbor is open only when it is inside the usable grid and still free.
  function automatic bit cell_open(int c, int r, int w, int h);
    return c >= 0 && r >= 0 && c < w && r < h && cell_mark_at(c, r) == gdw_pkg::MARK_FREE;
  endfunction

  // Applies one command item to the shadow walker and returns its response.
  function automatic gdw_pkg::rsp_t next_walker_rsp(gdw_pkg::cmd_t c);
    gdw_pkg::rsp_t r;
    int w, h, nc, nr;
    bit stuck;
    r = '0;
    case (c.operation)
      gdw_pkg::OP_WRITE: begin
        set_mark(c.cell_col, c.cell_row, c.is_wall ? gdw_pkg::MARK_WALL : gdw_pkg::MARK_FREE);
        r.status = gdw_pkg::ST_ACK;
      end
      gdw_pkg::OP_READ: begin
        r.cell_mark = cell_mark_at(c.cell_col, c.cell_row);
        r.status = gdw_pkg::ST_READ;
      end
      gdw_pkg::OP_BEGIN: begin
        at_col = start_c;
        at_row = start_r;
        trail_depth = 0;
        r.status = gdw_pkg::ST_ACK;
      end
      default: begin
        w = (grid_w > USE_COLS) ? USE_COLS : grid_w;
        h = (grid_h > USE_ROWS) ? USE_ROWS : grid_h;
        nc = at_col;
        nr = at_row;
        stuck = 1'b0;
        set_mark(nc, nr, gdw_pkg::MARK_PATH);
        if (at_col == goal_c && at_row == goal_r) begin
          r.status = gdw_pkg::ST_GOAL;
        end else begin
          // Probe order is +col, +row, -col, -row.
          if (cell_open(nc + 1, nr, w, h)) begin
            nc = nc + 1;
          end else if (cell_open(nc, nr + 1, w, h)) begin
            nr = nr + 1;
          end else if (cell_open(nc - 1, nr, w, h)) begin
            nc = nc - 1;
          end else if (cell_open(nc, nr - 1, w, h)) begin
            nr = nr - 1;
          end else begin
            stuck = 1'b1;
          end
          if (stuck) begin
            set_mark(nc, nr, gdw_pkg::MARK_DEAD);
            if (trail_depth == 0) begin
              // Dead end with nothing to return to: the walker stays put.
              r.status = gdw_pkg::ST_NOPATH;
            end else begin
              trail_depth--;
              if (trail_depth > 0) begin
                at_col = trail[trail_depth-1].col;
                at_row = trail[trail_depth-1].row;
              end else begin
                at_col = start_c;
                at_row = start_r;
              end
              r.status = gdw_pkg::ST_BACK;
            end
          end else begin
            at_col = nc[gdw_pkg::COORD_W-1:0];
            at_row = nr[gdw_pkg::COORD_W-1:0];
            // A full trail still moves the walker but drops the push.
            if (trail_depth < TRAIL_DEPTH) begin
              trail[trail_depth].col = at_col;
              trail[trail_depth].row = at_row;
              trail_depth++;
            end
            r.status = gdw_pkg::ST_FORWARD;
          end
        end
      end
    endcase
    r.walker_col = at_col;
    r.walker_row = at_row;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Command driver. A presented item stays put until it is accepted; the
  // prediction is made at the edge where the handshake completes.
  always @(posedge clk) begin : drive_cmds
    logic take;
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      take = cmd_valid && !cmd_stall;
      if (take) expected_rsps.push_back(next_walker_rsp(cmd));
      if (take || !cmd_valid) begin
        if (take && $urandom_range(0, 99) < idle_pct) begin
          send_gap = gap_len() - 1;
          cmd_valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Response monitor and stall generator. Twice in the run the receiver holds
  // off for a long stretch so that the walker backs up and stalls commands.
  always @(posedge clk) begin : check_rsps
    gdw_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response item with no prediction waiting");
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          report_field("walker_col", want.walker_col, rsp.walker_col);
          report_field("walker_row", want.walker_row, rsp.walker_row);
          report_field("status", want.status, rsp.status);
          report_field("cell_mark", want.cell_mark, rsp.cell_mark);
        end
        rsp_count++;
        if (rsp_count == 60 || rsp_count == 200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        recv_gap = gap_len() - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [1:0] op, int col, int row, bit wall);
    gdw_pkg::cmd_t c;
    c.operation = op;
    c.cell_col = col[gdw_pkg::COORD_W-1:0];
    c.cell_row = row[gdw_pkg::COORD_W-1:0];
    c.is_wall = wall;
    pending_cmds.push_back(c);
  endtask

  // Waits until every queued item has been accepted and answered. The test
  // runs at the falling edge, after the driver and the monitor have settled.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || cmd_valid)
      @(negedge clk);
  endtask

  // Writes all six registers back to back; only called while the walker is idle.
  task automatic configure_walk(int w, int h, int sc, int sr, int gc, int gr);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= gdw_pkg::CFG_GRID_WIDTH;
    cfg_data <= w[6:0];
    @(posedge clk);
    cfg_index <= gdw_pkg::CFG_GRID_HEIGHT;
    cfg_data <= h[6:0];
    @(posedge clk);
    cfg_index <= gdw_pkg::CFG_START_COL;
    cfg_data <= {1'b0, sc[5:0]};
    @(posedge clk);
    cfg_index <= gdw_pkg::CFG_START_ROW;
    cfg_data <= {1'b0, sr[5:0]};
    @(posedge clk);
    cfg_index <= gdw_pkg::CFG_GOAL_COL;
    cfg_data <= {1'b0, gc[5:0]};
    @(posedge clk);
    cfg_index <= gdw_pkg::CFG_GOAL_ROW;
    cfg_data <= {1'b0, gr[5:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_w = w[6:0];
    grid_h = h[6:0];
    start_c = sc[5:0];
    start_r = sr[5:0];
    goal_c = gc[5:0];
    goal_r = gr[5:0];
  endtask

  initial begin : stimulus
    int phase, random_items, w, h, gw, gh, sc, sr, gc, gr, cells, steps, col, row, pick;
    for (int r = 0; r < gdw_pkg::COORD_SPAN; r++)
      for (int c = 0; c < gdw_pkg::COORD_SPAN; c++)
        cell_store[r][c] = gdw_pkg::MARK_FREE;
    trail_depth = 0;
    at_col = '0;
    at_row = '0;
    grid_w = gdw_pkg::RST_GRID_WIDTH;
    grid_h = gdw_pkg::RST_GRID_HEIGHT;
    start_c = gdw_pkg::RST_START_COL;
    start_r = gdw_pkg::RST_START_ROW;
    goal_c = gdw_pkg::RST_GOAL_COL;
    goal_r = gdw_pkg::RST_GOAL_ROW;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A three by two grid with the goal walled in. The walk goes forward three
    // times, backtracks to stacked cells and then to the start, and finally
    // finds no path. A cell outside the grid is written and read on the way.
    configure_walk(3, 2, 0, 0, 2, 0);
    queue_cmd(gdw_pkg::OP_WRITE, 1, 0, 1'b1);
    queue_cmd(gdw_pkg::OP_WRITE, 2, 0, 1'b1);
    queue_cmd(gdw_pkg::OP_WRITE, 63, 63, 1'b1);
    queue_cmd(gdw_pkg::OP_READ, 63, 63, 1'b0);
    queue_cmd(gdw_pkg::OP_WRITE, 63, 63, 1'b0);
    queue_cmd(gdw_pkg::OP_READ, 0, 0, 1'b0);
    queue_cmd(gdw_pkg::OP_BEGIN, 0, 0, 1'b0);
    repeat (7) queue_cmd(gdw_pkg::OP_STEP, 0, 0, 1'b0);
    queue_cmd(gdw_pkg::OP_READ, 2, 1, 1'b0);
    queue_cmd(gdw_pkg::OP_READ, 0, 0, 1'b0);
    wait_drained();

    // Full-size grid with start and goal on the far corner: the first step
    // lands on the goal, and so does every later one.
    configure_walk(64, 64, 63, 63, 63, 63);
    queue_cmd(gdw_pkg::OP_BEGIN, 0, 0, 1'b0);
    queue_cmd(gdw_pkg::OP_STEP, 0, 0, 1'b0);
    queue_cmd(gdw_pkg::OP_READ, 63, 63, 1'b0);
    queue_cmd(gdw_pkg::OP_STEP, 0, 0, 1'b0);
    wait_drained();

    // Random mazes: lay out the walls, begin, then mostly steps with some
    // reads and a little noise in between.
    random_items = 0;
    phase = 0;
    while (random_items < 400 || phase < 6) begin
      idle_pct = (phase % 3 == 2) ? 0 : 25;
      case (phase % 6)
        1: begin
          gw = 64;
          gh = 64;
        end
        3: begin
          // Single cell or empty grid.
          gw = $urandom_range(0, 1);
          gh = $urandom_range(0, 1);
        end
        5: begin
          // Width beyond the coordinate reach, which the walker caps at 64.
          gw = $urandom_range(65, 127);
          gh = $urandom_range(2, 5);
        end
        default: begin
          gw = $urandom_range(2, 7);
          gh = $urandom_range(2, 7);
        end
      endcase
      w = (gw > USE_COLS) ? USE_COLS : gw;
      h = (gh > USE_ROWS) ? USE_ROWS : gh;
      // Now and then the start or goal lies outside the usable grid.
      if (w == 0 || h == 0 || $urandom_range(0, 4) == 0) begin
        sc = $urandom_range(0, 63);
        sr = $urandom_range(0, 63);
      end else begin
        sc = $urandom_range(0, w - 1);
        sr = $urandom_range(0, h - 1);
      end
      if (w == 0 || h == 0 || $urandom_range(0, 4) == 0) begin
        gc = $urandom_range(0, 63);
        gr = $urandom_range(0, 63);
      end else begin
        gc = $urandom_range(0, w - 1);
        gr = $urandom_range(0, h - 1);
      end
      configure_walk(gw, gh, sc, sr, gc, gr);

      // Small grids are rewritten cell by cell; a large one gets a scatter.
      cells = (w * h <= 49) ? w * h : 40;
      for (int i = 0; i < cells; i++) begin
        if (w * h <= 49) begin
          col = i % w;
          row = i / w;
        end else begin
          col = $urandom_range(0, w - 1);
          row = $urandom_range(0, h - 1);
        end
        queue_cmd(gdw_pkg::OP_WRITE, col, row,
                  !((col == sc && row == sr) || (col == gc && row == gr)) &&
                  $urandom_range(0, 99) < 30);
      end
      queue_cmd(gdw_pkg::OP_BEGIN, 0, 0, 1'b0);
      steps = (2 * w * h + 4 < 60) ? 2 * w * h + 4 : 60;
      for (int i = 0; i < steps; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          queue_cmd(gdw_pkg::OP_STEP, 0, 0, 1'b0);
        end else if (pick < 90 && w > 0 && h > 0) begin
          queue_cmd(gdw_pkg::OP_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    1'b0);
        end else begin
          queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                    1'($urandom_range(0, 1)));
        end
      end
      random_items += cells + steps + 1;
      wait_drained();
      phase++;
    end

    // Give a stray late response time to show up before the verdict.
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
